// ===== rtl/sedl_pkg.sv =====
// ============================================================================
// sedl_pkg: shared types and codes for the dedup ledger
// Request codes, verdict codes, entry flags and controller/datapath structs.
// ============================================================================
`default_nettype none
package sedl_pkg;

    localparam int REQ_BITS  = 3;
    localparam int VERD_BITS = 2;
    localparam int POL_BITS  = 2;
    localparam int CNT_BITS  = 32;
    localparam int DECL_BITS = 20;
    localparam int CFG_IDX_BITS = 3;
    localparam int CAP_BITS  = 7;

    // key field widths, fixed by the port list and the declaration packing
    localparam int KIND_BITS = 16;
    localparam int TICK_BITS = 32;

    localparam logic [2:0] REQ_REALISE = 3'd0;
    localparam logic [2:0] REQ_CONFIRM = 3'd1;
    localparam logic [2:0] REQ_INVAL   = 3'd2;
    localparam logic [2:0] REQ_PRUNE   = 3'd3;
    localparam logic [2:0] REQ_CLEAR   = 3'd4;

    localparam logic [1:0] V_REALISE = 2'd0;
    localparam logic [1:0] V_SUPP    = 2'd1;
    localparam logic [1:0] V_DEFER   = 2'd2;
    localparam logic [1:0] V_UNDECL  = 2'd3;

    localparam logic [2:0] CFG_SLOT_A = 3'd0;
    localparam logic [2:0] CFG_SLOT_B = 3'd1;
    localparam logic [2:0] CFG_SLOT_C = 3'd2;
    localparam logic [2:0] CFG_SLOT_D = 3'd3;
    localparam logic [2:0] CFG_CAP    = 3'd4;

    // entry flag bits
    localparam int FL_SPEC  = 0;
    localparam int FL_CONF  = 1;
    localparam int FL_INVAL = 2;

    // controller to datapath
    typedef struct packed {
        logic load;       // capture request
        logic scan_clr;   // reset scan and write indices and the oldest-tick minimum
        logic scan_step;  // process entry at scan index (read data valid)
        logic drop_front; // shift-out pass start
        logic finish;     // apply final updates and present result
    } sedl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic scan_last;  // scan index reached held count
        logic need_drop;  // append needs a front drop
    } sedl_sts_t;

endpackage
`default_nettype wire

// ===== rtl/sedl_ram.sv =====
// ============================================================================
// sedl_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ============================================================================
`default_nettype none
module sedl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// ===== rtl/sedl_ctrl.sv =====
// ============================================================================
// sedl_ctrl: request sequencer
// Steps through a read/modify/compact pass over the held entries.
// ============================================================================
`default_nettype none
module sedl_ctrl
    import sedl_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      start,
    input  wire sedl_sts_t sts,
    output logic           busy,
    output sedl_cmd_t      cmd
);
    typedef enum logic [2:0] {
        ST_IDLE, ST_PRIME, ST_SCAN, ST_DROP, ST_FIN
    } state_t;

    state_t state_reg, state_next;
    logic   busy_next;

    // next state
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_PRIME;
                end
            end
            ST_PRIME:
            begin
                // first read address presented; data valid next cycle
                cmd.scan_clr = 1'b1;
                state_next   = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (sts.scan_last)
                begin
                    if (sts.need_drop)
                    begin
                        cmd.drop_front = 1'b1;
                        state_next     = ST_DROP;
                    end
                    else
                    begin
                        state_next = ST_FIN;
                    end
                end
                else
                begin
                    cmd.scan_step = 1'b1;
                end
            end
            ST_DROP:
            begin
                // drop pass rescans and compacts past front entry
                cmd.scan_clr = 1'b1;
                state_next   = ST_SCAN;
            end
            ST_FIN:
            begin
                cmd.finish = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy_next = (state_next != ST_IDLE);

    // state and registered busy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            busy      <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            busy      <= busy_next;
        end
    end

`ifndef SYNTH
    a_busy_idle: assert property (@(posedge clk) disable iff (!rst_n)
        busy == (state_reg != ST_IDLE))
        else $error("busy out of step with state");
    a_fin_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> !busy)
        else $error("finish not followed by idle");
    a_load_prime: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> (state_reg == ST_PRIME))
        else $error("load not followed by prime");
`endif
endmodule
`default_nettype wire

// ===== rtl/sedl_dp.sv =====
// ============================================================================
// sedl_dp: ledger datapath
// Entry RAM, scan pointers, compaction, counters and result registers.
// Each scan reads entry rd_idx and writes the kept/modified entry at wr_idx,
// so confirm, invalidate, prune and front drop all run as one streaming pass.
// ============================================================================
`default_nettype none
module sedl_dp
    import sedl_pkg::*;
#(
    parameter int ENTRIES    = 64,
    parameter int DECL_SLOTS = 4
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire sedl_cmd_t               cmd,
    output sedl_sts_t                    sts,
    input  wire logic                    cfg_we,
    input  wire logic [CFG_IDX_BITS-1:0] cfg_idx,
    input  wire logic [DECL_BITS-1:0]    cfg_data,
    input  wire logic [REQ_BITS-1:0]     req_type,
    input  wire logic [15:0]             effect_kind,
    input  wire logic [31:0]             effect_instance,
    input  wire logic [31:0]             sim_tick,
    input  wire logic                    is_predicted,
    output logic                         done,
    output logic [VERD_BITS-1:0]         verdict,
    output logic [POL_BITS-1:0]          policy,
    output logic [CAP_BITS-1:0]          released,
    output logic [31:0]                  earliest_tick,
    output logic [CAP_BITS-1:0]          entries_held,
    output logic [CNT_BITS-1:0]          count_realised,
    output logic [CNT_BITS-1:0]          count_suppressed,
    output logic [CNT_BITS-1:0]          count_deferred,
    output logic [CNT_BITS-1:0]          count_undeclared,
    output logic [CNT_BITS-1:0]          count_invalidated,
    output logic [CNT_BITS-1:0]          count_dropped
);
    localparam int AW = $clog2(ENTRIES);
    localparam int CW = $clog2(ENTRIES + 1);
    localparam int EW = KIND_BITS + 32 + TICK_BITS + 3;

    // ---- configuration ----
    logic [DECL_BITS-1:0] decl_reg [4];
    logic [CAP_BITS-1:0]  cap_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < 4; s++)
            begin
                decl_reg[s] <= '0;
            end
            cap_reg <= CAP_BITS'(64);
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx)
                CFG_SLOT_A, CFG_SLOT_B, CFG_SLOT_C, CFG_SLOT_D:
                    decl_reg[cfg_idx[1:0]] <= cfg_data;
                CFG_CAP:
                    cap_reg <= cfg_data[CAP_BITS-1:0];
                default: ;
            endcase
        end
    end

    // ---- captured request ----
    logic [REQ_BITS-1:0]  req_reg;
    logic [KIND_BITS-1:0] kind_reg;
    logic [31:0]          inst_reg;
    logic [TICK_BITS-1:0] tick_reg;
    logic                 pred_reg;
    logic                 dropping_reg; // current pass is a front drop

    // declaration lookup, first matching slot wins
    logic       decl_hit;
    logic       decl_conf_only;
    logic [1:0] decl_pol;

    always_comb
    begin
        decl_hit       = 1'b0;
        decl_conf_only = 1'b0;
        decl_pol       = 2'd0;
        for (int s = 3; s >= 0; s--)
        begin
            if (s < DECL_SLOTS && kind_reg != '0 && decl_reg[s][15:0] == kind_reg)
            begin
                decl_hit       = 1'b1;
                decl_conf_only = decl_reg[s][16];
                decl_pol       = (decl_reg[s][18:17] == 2'd3) ? 2'd0 : decl_reg[s][18:17];
            end
        end
    end

    // effective capacity
    logic [CW-1:0] cap_eff;
    always_comb
    begin
        if (cap_reg == '0)
        begin
            cap_eff = CW'(1);
        end
        else if (32'(cap_reg) > ENTRIES)
        begin
            cap_eff = CW'(ENTRIES);
        end
        else
        begin
            cap_eff = CW'(cap_reg);
        end
    end

    // ---- scan pointers ----
    logic [CW-1:0] held_reg;
    logic [CW-1:0] rd_idx_reg;   // entry whose data is on ram output
    logic [CW-1:0] wr_idx_reg;   // compaction write slot
    logic [CW-1:0] raddr_cnt;
    logic          found_reg;    // key match seen
    logic [2:0]    found_flags_reg;
    logic [CAP_BITS-1:0] rel_reg;
    logic [TICK_BITS-1:0] old_reg;
    logic          inval_hit_reg;

    // entry RAM
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [EW-1:0] ram_wdata;
    logic [EW-1:0] ram_rdata;

    sedl_ram #(.WIDTH(EW), .DEPTH(ENTRIES)) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (raddr_cnt[AW-1:0]),
        .rdata (ram_rdata)
    );

    logic [KIND_BITS-1:0] e_kind;
    logic [31:0]          e_inst;
    logic [TICK_BITS-1:0] e_tick;
    logic [2:0]           e_flags;
    assign {e_kind, e_inst, e_tick, e_flags} = ram_rdata;

    logic key_match;
    assign key_match = (e_kind == kind_reg) && (e_inst == inst_reg)
                       && (e_tick == tick_reg);

    // per entry decision during a pass
    logic          keep;
    logic [2:0]    new_flags;
    logic          rel_inc;
    logic          inval_now;
    always_comb
    begin
        keep      = 1'b1;
        new_flags = e_flags;
        rel_inc   = 1'b0;
        inval_now = 1'b0;
        if (dropping_reg)
        begin
            keep = (rd_idx_reg != '0);
        end
        else
        begin
            case (req_reg)
                REQ_CONFIRM:
                begin
                    if (e_tick <= tick_reg && e_flags[FL_SPEC] && !e_flags[FL_CONF]
                        && !e_flags[FL_INVAL])
                    begin
                        new_flags[FL_CONF] = 1'b1;
                        rel_inc            = 1'b1;
                    end
                end
                REQ_INVAL:
                begin
                    if (key_match && !found_reg && !e_flags[FL_INVAL])
                    begin
                        new_flags[FL_INVAL] = 1'b1;
                        inval_now           = 1'b1;
                    end
                end
                REQ_PRUNE:
                begin
                    keep = (e_tick >= tick_reg);
                end
                default: ;
            endcase
        end
    end

    // append decision after search
    logic do_append;
    logic [2:0] app_flags;
    logic [VERD_BITS-1:0] verd_w;
    always_comb
    begin
        do_append = 1'b0;
        app_flags = 3'b000;
        verd_w    = V_REALISE;
        if (!decl_hit)
        begin
            verd_w = V_UNDECL;
        end
        else if (found_reg)
        begin
            verd_w = (found_flags_reg[FL_CONF] || !pred_reg || !decl_conf_only)
                     ? V_SUPP : V_DEFER;
        end
        else
        begin
            do_append = 1'b1;
            verd_w    = (pred_reg && decl_conf_only) ? V_DEFER : V_REALISE;
            app_flags[FL_SPEC] = pred_reg;
            app_flags[FL_CONF] = !pred_reg;
        end
    end

    logic is_real;
    assign is_real = (req_reg == REQ_REALISE);

    // every request but clear walks the held entries, so the oldest tick is known
    assign sts.scan_last = (rd_idx_reg >= held_reg) || (req_reg == REQ_CLEAR);
    assign sts.need_drop = is_real && do_append && !dropping_reg
                           && held_reg != '0 && held_reg >= cap_eff;

    // RAM write: compaction during scan, append at finish
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = wr_idx_reg[AW-1:0];
        ram_wdata = {e_kind, e_inst, e_tick, new_flags};
        if (cmd.scan_step && keep)
        begin
            ram_we = 1'b1;
        end
        else if (cmd.finish && is_real && do_append)
        begin
            ram_we    = 1'b1;
            ram_wdata = {kind_reg, inst_reg, tick_reg, app_flags};
        end
    end

    // tallies
    logic [CNT_BITS-1:0] tally_reg [6];

    // pointers, accumulators, results
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg        <= '0;
            done            <= 1'b0;
            dropping_reg    <= 1'b0;
            rd_idx_reg      <= '0;
            wr_idx_reg      <= '0;
            raddr_cnt       <= '0;
            found_reg       <= 1'b0;
            found_flags_reg <= '0;
            rel_reg         <= '0;
            inval_hit_reg   <= 1'b0;
            for (int t = 0; t < 6; t++)
            begin
                tally_reg[t] <= '0;
            end
        end
        else
        begin
            done <= cmd.finish;
            if (cmd.load)
            begin
                dropping_reg <= 1'b0;
                raddr_cnt    <= '0;
                rel_reg      <= '0;
                found_reg    <= 1'b0;
                inval_hit_reg <= 1'b0;
            end
            if (cmd.drop_front)
            begin
                dropping_reg <= 1'b1;
                raddr_cnt    <= '0;
            end
            if (cmd.scan_clr)
            begin
                rd_idx_reg <= '0;
                wr_idx_reg <= '0;
                raddr_cnt  <= CW'(1);
            end
            if (cmd.scan_step)
            begin
                rd_idx_reg <= rd_idx_reg + CW'(1);
                raddr_cnt  <= raddr_cnt + CW'(1);
                if (keep)
                begin
                    wr_idx_reg <= wr_idx_reg + CW'(1);
                end
                if (!dropping_reg && key_match && !found_reg)
                begin
                    found_reg       <= 1'b1;
                    found_flags_reg <= e_flags;
                end
                if (rel_inc)
                begin
                    rel_reg <= rel_reg + CAP_BITS'(1);
                end
                if (inval_now)
                begin
                    inval_hit_reg <= 1'b1;
                end
            end
            // start of a drop pass: count the front entry as dropped
            if (cmd.scan_clr && dropping_reg)
            begin
                tally_reg[5] <= tally_reg[5] + CNT_BITS'(1);
            end
            if (cmd.finish)
            begin
                case (req_reg)
                    REQ_REALISE:
                    begin
                        tally_reg[verd_w] <= tally_reg[verd_w] + CNT_BITS'(1);
                        if (do_append)
                        begin
                            held_reg <= wr_idx_reg + CW'(1);
                        end
                    end
                    REQ_INVAL:
                    begin
                        if (inval_hit_reg)
                        begin
                            tally_reg[4] <= tally_reg[4] + CNT_BITS'(1);
                        end
                    end
                    REQ_PRUNE:
                    begin
                        held_reg <= wr_idx_reg;
                    end
                    REQ_CLEAR:
                    begin
                        held_reg <= '0;
                        for (int t = 0; t < 6; t++)
                        begin
                            tally_reg[t] <= '0;
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    // drop pass walks the full held range again from index 0; the front entry
    // is skipped via keep=0, so wr_idx ends one short and the append fills it

    // oldest tick: running minimum over kept entries
    logic [TICK_BITS-1:0] min_next;
    logic                 min_any_reg;
    always_ff @(posedge clk)
    begin
        if (cmd.scan_clr)
        begin
            min_any_reg <= 1'b0;
        end
        else if (cmd.scan_step && keep)
        begin
            if (!min_any_reg || e_tick < old_reg)
            begin
                old_reg <= e_tick;
            end
            min_any_reg <= 1'b1;
        end
        if (cmd.load)
        begin
            req_reg  <= req_type;
            kind_reg <= KIND_BITS'(effect_kind);
            inst_reg <= effect_instance;
            tick_reg <= TICK_BITS'(sim_tick);
            pred_reg <= is_predicted;
            min_any_reg <= 1'b0;
        end
    end

    assign min_next = min_any_reg ? old_reg : '0;

    // result registers
    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            verdict  <= is_real ? verd_w : V_REALISE;
            policy   <= (req_reg == REQ_INVAL) ? decl_pol : 2'd0;
            released <= (req_reg == REQ_CONFIRM) ? rel_reg : '0;
            if (req_reg == REQ_CLEAR || ((req_reg == REQ_PRUNE) && wr_idx_reg == '0))
            begin
                earliest_tick <= '0;
            end
            else if (is_real && do_append && (!min_any_reg || tick_reg < old_reg))
            begin
                earliest_tick <= 32'(tick_reg);
            end
            else
            begin
                earliest_tick <= 32'(min_next);
            end
        end
    end

    assign entries_held      = CAP_BITS'(held_reg);
    assign count_realised    = tally_reg[0];
    assign count_suppressed  = tally_reg[1];
    assign count_deferred    = tally_reg[2];
    assign count_undeclared  = tally_reg[3];
    assign count_invalidated = tally_reg[4];
    assign count_dropped     = tally_reg[5];

`ifndef SYNTH
    a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
        held_reg <= CW'(ENTRIES))
        else $error("held count beyond table depth");
    a_wr_le_rd: assert property (@(posedge clk) disable iff (!rst_n)
        wr_idx_reg <= rd_idx_reg)
        else $error("compaction overtook read");
    a_drop_one: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.drop_front |=> dropping_reg)
        else $error("drop pass not flagged");
`endif
endmodule
`default_nettype wire

// ===== rtl/side_effect_dedup_ledger.sv =====
// ============================================================================
// side_effect_dedup_ledger: effect dedup ledger top level
// Ordered entry table with realise/confirm/invalidate/prune/clear requests.
// ============================================================================
// A request is taken when start is high and busy is low; its result appears
// on the result ports for one cycle with done high and cannot be held off.
// Every request but clear makes one streaming pass over the held entries
// through the entry RAM (one entry per cycle, registered read), and a
// realise that must drop the oldest entry at capacity makes a second pass.
// Configuration writes take effect at once and are meant for idle periods
// only.
`default_nettype none
module side_effect_dedup_ledger
    import sedl_pkg::*;
#(
    parameter int ENTRIES    = 64,
    parameter int DECL_SLOTS = 4
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    start,
    output logic                         busy,
    output logic                         done,
    input  wire logic                    cfg_we,
    input  wire logic [CFG_IDX_BITS-1:0] cfg_idx,
    input  wire logic [DECL_BITS-1:0]    cfg_data,
    input  wire logic [2:0]              req_type,
    input  wire logic [15:0]             effect_kind,
    input  wire logic [31:0]             effect_instance,
    input  wire logic [31:0]             sim_tick,
    input  wire logic                    is_predicted,
    output logic [1:0]                   verdict,
    output logic [1:0]                   policy,
    output logic [6:0]                   released,
    output logic [31:0]                  earliest_tick,
    output logic [6:0]                   entries_held,
    output logic [31:0]                  count_realised,
    output logic [31:0]                  count_suppressed,
    output logic [31:0]                  count_deferred,
    output logic [31:0]                  count_undeclared,
    output logic [31:0]                  count_invalidated,
    output logic [31:0]                  count_dropped
);
    sedl_cmd_t cmd;
    sedl_sts_t sts;

    // sequencer
    sedl_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .busy  (busy),
        .cmd   (cmd)
    );

    // table and counters
    sedl_dp #(
        .ENTRIES    (ENTRIES),
        .DECL_SLOTS (DECL_SLOTS)
    ) u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .sts               (sts),
        .cfg_we            (cfg_we),
        .cfg_idx           (cfg_idx),
        .cfg_data          (cfg_data),
        .req_type          (req_type),
        .effect_kind       (effect_kind),
        .effect_instance   (effect_instance),
        .sim_tick          (sim_tick),
        .is_predicted      (is_predicted),
        .done              (done),
        .verdict           (verdict),
        .policy            (policy),
        .released          (released),
        .earliest_tick     (earliest_tick),
        .entries_held      (entries_held),
        .count_realised    (count_realised),
        .count_suppressed  (count_suppressed),
        .count_deferred    (count_deferred),
        .count_undeclared  (count_undeclared),
        .count_invalidated (count_invalidated),
        .count_dropped     (count_dropped)
    );

`ifndef SYNTH
    a_no_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result without a request in flight");
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted request did not raise busy");
    a_held_cap: assert property (@(posedge clk) disable iff (!rst_n)
        entries_held <= 7'(ENTRIES))
        else $error("held count out of range");
`endif
endmodule
`default_nettype wire
